/* rtl/core/crmp_pkg.sv */
// shared constants for the conv3x3 relu maxpool layer
package crmp_pkg;
  localparam int ImageSize = 48;
  localparam int OutChannels = 16;
  localparam int WeightFracBits = 13;
  localparam int ConvSize = ImageSize - 2;
  localparam int PoolSize = ConvSize / 2;
  localparam int WeightCount = 9 * OutChannels;
  localparam int ChW = 4;
  localparam int PosW = 6;
  localparam int PcW = 5;
  localparam int WAddrW = 8;
  localparam int RpmDepth = PoolSize * OutChannels;
  localparam int RpmAddrW = 9;
  localparam int LineAddrW = 6;
  localparam int AccW = 40;

  localparam logic [1:0] FUNC_WEIGHT = 2'd0;
  localparam logic [1:0] FUNC_BIAS = 2'd1;
  localparam logic [1:0] FUNC_PIXEL = 2'd2;
  localparam logic [1:0] FUNC_NONE = 2'd3;
endpackage

/* rtl/core/conv3x3_relu_maxpool2x2.sv */
// top level: conv3x3 relu maxpool layer with a shared multiply-accumulate unit
// Weight and bias words are taken one per cycle while the layer is idle. A pixel is taken in
// the idle state and is followed by the line buffer update and window shift before the next
// word is taken. A pixel that completes a conv position then runs the 16 channels through
// one shared multiplier: a bias step and nine taps, then relu, pooling and output per
// channel, before the next word is taken; an emitted result can also wait for out_tready
// while the previous result is still held. Results for a pooled position come out channel
// 0 first, last marks channel 15.
module conv3x3_relu_maxpool2x2
  import crmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,  // index[7:0], value[23:8]
  input  logic [2:0]  in_tuser,  // func[1:0], frame_start[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // channel[3:0], out_row[8:4], out_col[13:9], pool_value[28:14]
  output logic        out_tlast
);
  localparam logic [2:0] S_IDLE = 3'd0, S_LINE = 3'd1, S_WIN = 3'd2, S_MAC = 3'd3,
                         S_DONE = 3'd4, S_POOL = 3'd5, S_OUT = 3'd6;

  logic [2:0] st_r, st_nxt;
  logic [1:0] func;
  logic [7:0] idx;
  logic signed [15:0] val;
  logic fstart;
  logic in_acc;
  assign func = in_tuser[1:0];
  assign fstart = in_tuser[2];
  assign idx = in_tdata[7:0];
  assign val = in_tdata[23:8];
  assign in_acc = in_tvalid && in_tready;

  logic [PosW-1:0] row_r, col_r, y_r, x_r;
  logic signed [15:0] pix_r;
  logic signed [15:0] win_r [9];
  logic signed [15:0] bias_r [OutChannels];
  logic [ChW-1:0] ch_r;
  logic [3:0] tap_r;
  logic signed [AccW-1:0] acc_r;
  logic [14:0] colmax_r [OutChannels];
  logic [14:0] res_r, m_r;
  logic [31:0] od_r;
  logic ov_r, ol_r;

  logic [PosW-1:0] col_nx;
  assign col_nx = fstart ? '0 : col_r;

  // line buffers
  logic la_we, lb_we;
  logic signed [15:0] la_q, lb_q;
  crmp_ram #(.Width(16), .Depth(ImageSize), .AddrW(LineAddrW)) u_la (
    .clk, .we(la_we), .waddr(x_r), .wdata(lb_q), .raddr(col_nx), .rdata(la_q));
  crmp_ram #(.Width(16), .Depth(ImageSize), .AddrW(LineAddrW)) u_lb (
    .clk, .we(lb_we), .waddr(x_r), .wdata(pix_r), .raddr(col_nx), .rdata(lb_q));

  // weights: address tap*16+ch
  logic w_we;
  logic [WAddrW-1:0] w_ra;
  logic signed [15:0] w_q;
  assign w_we = in_acc && func == FUNC_WEIGHT && idx < WAddrW'(WeightCount);
  assign w_ra = WAddrW'({tap_r, ch_r});
  crmp_ram #(.Width(16), .Depth(WeightCount), .AddrW(WAddrW)) u_w (
    .clk, .we(w_we), .waddr(idx), .wdata(val), .raddr(w_ra), .rdata(w_q));

  // row pair max
  logic rp_we;
  logic [RpmAddrW-1:0] rp_a;
  logic [14:0] rp_q;
  logic [PcW-1:0] pc, prow;
  assign pc = PcW'((x_r - PosW'(2)) >> 1);
  assign prow = PcW'((y_r - PosW'(2)) >> 1);
  assign rp_a = RpmAddrW'({pc, ch_r});
  crmp_ram #(.Width(15), .Depth(RpmDepth), .AddrW(RpmAddrW)) u_rp (
    .clk, .we(rp_we), .waddr(rp_a), .wdata(m_r), .raddr(rp_a), .rdata(rp_q));

  // the registered weight read lags the tap counter, so the product uses tap - 1
  logic [3:0] tap_m1;
  logic signed [31:0] prod;
  assign tap_m1 = tap_r - 4'd1;
  assign prod = win_r[tap_m1] * w_q;
  logic signed [AccW-WeightFracBits-1:0] sh;
  assign sh = acc_r[AccW-1:WeightFracBits];
  logic [14:0] relu;
  always_comb begin
    if (acc_r <= 0) relu = '0;
    else if (sh > 32767) relu = 15'h7fff;
    else relu = sh[14:0];
  end
  logic cxodd, cyodd, emit_pos, out_free, emit;
  assign cxodd = x_r[0]; // cx = x-2 has same parity as x
  assign cyodd = y_r[0];
  assign emit_pos = cxodd && cyodd;
  assign out_free = !ov_r || out_tready;
  assign emit = (st_r == S_OUT) && emit_pos && out_free;

  assign in_tready = (st_r == S_IDLE);
  assign la_we = (st_r == S_LINE);
  assign lb_we = (st_r == S_LINE);
  assign rp_we = (st_r == S_OUT) && cxodd && !cyodd;
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign out_tlast = ol_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (in_acc && func == FUNC_PIXEL) st_nxt = S_LINE;
      S_LINE: st_nxt = S_WIN;
      S_WIN: st_nxt = (y_r >= PosW'(2) && x_r >= PosW'(2)) ? S_MAC : S_IDLE;
      S_MAC: if (tap_r == 4'd9) st_nxt = S_DONE;
      S_DONE: st_nxt = S_POOL;
      S_POOL: st_nxt = S_OUT;
      S_OUT: if (!emit_pos || out_free)
        st_nxt = (ch_r == ChW'(OutChannels - 1)) ? S_IDLE : S_MAC;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      row_r <= '0;
      col_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (emit) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            if (func == FUNC_BIAS && idx < 8'(OutChannels)) bias_r[idx[ChW-1:0]] <= val;
            if (func == FUNC_PIXEL) begin
              y_r <= fstart ? '0 : row_r;
              x_r <= col_nx;
              pix_r <= val;
            end
          end
        end
        S_LINE: begin
          for (int k = 0; k < 3; k++) begin
            win_r[k*3] <= win_r[k*3+1];
            win_r[k*3+1] <= win_r[k*3+2];
          end
          win_r[2] <= la_q;
          win_r[5] <= lb_q;
          win_r[8] <= pix_r;
          if (x_r == PosW'(ImageSize - 1)) begin
            col_r <= '0;
            row_r <= (y_r == PosW'(ImageSize - 1)) ? '0 : y_r + 1'b1;
          end else begin
            col_r <= x_r + 1'b1;
            row_r <= y_r;
          end
        end
        S_WIN: begin
          ch_r <= '0;
          tap_r <= '0;
        end
        S_MAC: begin
          // tap 0 loads the bias while the first weight is read
          if (tap_r == 4'd0)
            acc_r <= AccW'(bias_r[ch_r]) <<< WeightFracBits;
          else
            acc_r <= acc_r + AccW'(prod);
          if (tap_r != 4'd9) tap_r <= tap_r + 1'b1;
        end
        S_DONE: begin
          res_r <= relu;
        end
        S_POOL: begin
          m_r <= (colmax_r[ch_r] > res_r) ? colmax_r[ch_r] : res_r;
          if (!cxodd) colmax_r[ch_r] <= res_r;
        end
        S_OUT: begin
          if (!emit_pos || out_free) begin
            if (emit_pos) begin
              od_r <= {3'b000, (rp_q > m_r) ? rp_q : m_r, pc, prow, ch_r};
              ol_r <= (ch_r == ChW'(OutChannels - 1));
            end
            ch_r <= ch_r + 1'b1;
            tap_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

/* rtl/core/crmp_ram.sv */
// generic single-port-write ram with registered read
module crmp_ram #(
  parameter int Width = 16,
  parameter int Depth = 16,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
